// ----- hw/rtl/snjm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package snjm_pkg;

    // Number of pad buttons shifted in per frame.
    localparam int BUTTON_COUNT_DEFAULT = 8;

    // Configuration register widths and reset values.
    localparam int HALF_PERIOD_W = 16;
    localparam int FRAME_GAP_W   = 20;
    localparam int TICK_W        = 20;

    localparam logic [HALF_PERIOD_W-1:0] HALF_PERIOD_RESET = 16'd25;
    localparam logic [FRAME_GAP_W-1:0]   FRAME_GAP_RESET   = 20'd20000;

    // Configuration port geometry.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register indexes, decoded from paddr[2].
    localparam logic REG_HALF_PERIOD = 1'b0;
    localparam logic REG_FRAME_GAP   = 1'b1;

    // Stream payload widths.
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 8;
    localparam int IN_FIELDS_W = 3;
    localparam int RESULT_W    = 6;

    typedef struct packed {
        logic [FRAME_GAP_W-1:0]   frame_gap_ticks;
        logic [HALF_PERIOD_W-1:0] half_period_ticks;
    } cfg_t;

    // Sequencer view of one tick: strobes and the first eight button bits
    // (A, B, select, start, up, down, left, right from bit 0 up).
    typedef struct packed {
        logic [7:0] pad_bits;
        logic       pulse;
        logic       latch;
    } seq_info_t;

    // One result beat, latch_out in the lowest bit.
    typedef struct packed {
        logic down_or_start_n;
        logic up_or_select_n;
        logic left_or_b_n;
        logic right_or_a_n;
        logic pulse_out;
        logic latch_out;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/snjm_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module snjm_regs (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [snjm_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [snjm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic      [snjm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                                  pready,
    output snjm_pkg::cfg_t                        cfg
);

    snjm_pkg::cfg_t cfg_reg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.half_period_ticks <= snjm_pkg::HALF_PERIOD_RESET;
            cfg_reg.frame_gap_ticks   <= snjm_pkg::FRAME_GAP_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                snjm_pkg::REG_HALF_PERIOD:
                    cfg_reg.half_period_ticks <= pwdata[snjm_pkg::HALF_PERIOD_W-1:0];
                snjm_pkg::REG_FRAME_GAP:
                    cfg_reg.frame_gap_ticks <= pwdata[snjm_pkg::FRAME_GAP_W-1:0];
                default:
                    cfg_reg.half_period_ticks <= cfg_reg.half_period_ticks;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            snjm_pkg::REG_HALF_PERIOD:
                prdata = {{(snjm_pkg::APB_DATA_W-snjm_pkg::HALF_PERIOD_W){1'b0}},
                          cfg_reg.half_period_ticks};
            snjm_pkg::REG_FRAME_GAP:
                prdata = {{(snjm_pkg::APB_DATA_W-snjm_pkg::FRAME_GAP_W){1'b0}},
                          cfg_reg.frame_gap_ticks};
            default:
                prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/snjm_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module snjm_seq #(
    parameter int BUTTON_COUNT = snjm_pkg::BUTTON_COUNT_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire logic              serial_data,
    input  snjm_pkg::cfg_t         cfg,
    output snjm_pkg::seq_info_t    info
);

    localparam int IDX_W = $clog2(BUTTON_COUNT);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUTTON_COUNT - 1);

    typedef enum logic [2:0] {
        PH_LATCH_HI = 3'd0,
        PH_LATCH_LO = 3'd1,
        PH_PULSE_HI = 3'd2,
        PH_PULSE_LO = 3'd3,
        PH_GAP      = 3'd4
    } phase_t;

    phase_t                        phase_reg,  phase_next;
    logic [snjm_pkg::TICK_W-1:0]   tick_reg,   tick_next;
    logic [IDX_W-1:0]              index_reg,  index_next;
    logic [BUTTON_COUNT-1:0]       buttons_reg, buttons_next;

    logic [snjm_pkg::TICK_W-1:0]   len;
    logic [snjm_pkg::TICK_W-1:0]   tick_inc;
    logic                          finish;
    logic                          sample;

    // The sample taken on the first pulse-high tick already shows on this
    // tick's matrix lines, so the result uses the next button value.
    always_comb
    begin
        sample       = (phase_reg == PH_PULSE_HI) && (tick_reg == '0);
        buttons_next = buttons_reg;
        if (sample)
        begin
            buttons_next[index_reg] = serial_data;
        end

        if (phase_reg == PH_GAP)
        begin
            len = cfg.frame_gap_ticks;
        end
        else
        begin
            len = snjm_pkg::TICK_W'(cfg.half_period_ticks);
        end
        if (len == '0)
        begin
            len = snjm_pkg::TICK_W'(1);
        end

        tick_inc = tick_reg + snjm_pkg::TICK_W'(1);
        finish   = (tick_inc >= len) || (tick_inc == '0);

        phase_next = phase_reg;
        index_next = index_reg;
        tick_next  = tick_inc;
        if (finish)
        begin
            tick_next = '0;
            unique case (phase_reg)
                PH_LATCH_HI:
                    phase_next = PH_LATCH_LO;
                PH_LATCH_LO:
                begin
                    index_next = '0;
                    phase_next = PH_PULSE_HI;
                end
                PH_PULSE_HI:
                    phase_next = PH_PULSE_LO;
                PH_PULSE_LO:
                begin
                    if (index_reg == LAST_IDX)
                    begin
                        index_next = '0;
                        phase_next = (cfg.frame_gap_ticks == '0) ? PH_LATCH_HI : PH_GAP;
                    end
                    else
                    begin
                        index_next = index_reg + IDX_W'(1);
                        phase_next = PH_PULSE_HI;
                    end
                end
                default:
                    phase_next = PH_LATCH_HI;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LATCH_HI;
            tick_reg    <= '0;
            index_reg   <= '0;
            buttons_reg <= '1;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            index_reg   <= index_next;
            buttons_reg <= buttons_next;
        end
    end

    assign info.latch    = (phase_reg == PH_LATCH_HI);
    assign info.pulse    = (phase_reg == PH_PULSE_HI);
    assign info.pad_bits = buttons_next[7:0];

`ifndef SYNTHESIS
    a_strobes_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        !(info.latch && info.pulse))
        else $error("latch and pulse high on the same tick");

    a_index_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_PULSE_HI && phase_reg != PH_PULSE_LO) |-> (index_reg == '0))
        else $error("bit index not cleared outside the bit slots");

    a_buttons_only_on_sample: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && sample) |=> $stable(buttons_reg))
        else $error("button register changed outside a sample tick");

    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> ($stable(phase_reg) && $stable(tick_reg)))
        else $error("sequencer moved without an accepted tick");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/snjm_matrix.sv -----
`timescale 1ns / 1ps
`default_nettype none

module snjm_matrix (
    input  snjm_pkg::seq_info_t  info,
    input  wire logic            dpad_select_n,
    input  wire logic            action_select_n,
    output snjm_pkg::result_t    result
);

    logic [7:0] b;

    assign b = info.pad_bits;

    always_comb
    begin
        result.latch_out = info.latch;
        result.pulse_out = info.pulse;
        priority if (!dpad_select_n)
        begin
            result.right_or_a_n    = b[7];
            result.left_or_b_n     = b[6];
            result.up_or_select_n  = b[4];
            result.down_or_start_n = b[5];
        end
        else if (!action_select_n)
        begin
            result.right_or_a_n    = b[0];
            result.left_or_b_n     = b[1];
            result.up_or_select_n  = b[2];
            result.down_or_start_n = b[3];
        end
        else
        begin
            result.right_or_a_n    = 1'b1;
            result.left_or_b_n     = 1'b1;
            result.up_or_select_n  = 1'b1;
            result.down_or_start_n = 1'b1;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/serial_pad_to_joypad_matrix.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Serial pad reader that drives an active-low joypad matrix. Every input
// beat is one timing tick and produces exactly one output beat. The block
// takes a beat every clock cycle while the result stream does not stall.
// A tick is held in the input register and its result in the result
// register, which drives m_tvalid. While the result stream stalls, one
// more tick can wait in the input register, and then s_tready drops until
// the result register drains. On each tick the sequencer steps through a
// latch-high and a latch-low half period, then BUTTON_COUNT bit slots
// (pulse high, then pulse low), then a frame gap, and starts again. The
// pad data pin is sampled on the first tick of each pulse-high half
// period, and that sample already shows on the matrix lines of the same
// tick. The matrix lines show the direction row while dpad_select_n is
// low, else the action row while action_select_n is low, else all ones.
// The button register resets to all ones (released). Both timing
// registers are on the APB port: half_period_ticks at byte address 0 and
// frame_gap_ticks at byte address 4; a half period of zero acts as one
// and a frame gap of zero skips the gap. Change them only while idle.
module serial_pad_to_joypad_matrix #(
    parameter int BUTTON_COUNT = snjm_pkg::BUTTON_COUNT_DEFAULT
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,

    // Input stream. tdata from bit 0: serial_data, dpad_select_n,
    // action_select_n, then zero fill.
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [snjm_pkg::IN_TDATA_W-1:0]     s_tdata,

    // Result stream. tdata from bit 0: latch_out, pulse_out, right_or_a_n,
    // left_or_b_n, up_or_select_n, down_or_start_n, then zero fill.
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [snjm_pkg::OUT_TDATA_W-1:0]    m_tdata,

    // Configuration port.
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [snjm_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire logic [snjm_pkg::APB_DATA_W-1:0]     pwdata,
    output logic      [snjm_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                     pready
);

    snjm_pkg::cfg_t       cfg;
    snjm_pkg::seq_info_t  info;
    snjm_pkg::result_t    result;

    // Input register holds one tick; the result register holds one beat.
    logic                                 in_valid_reg;
    logic [snjm_pkg::IN_FIELDS_W-1:0]     in_data_reg;
    logic                                 out_valid_reg;
    snjm_pkg::result_t                    out_data_reg;
    logic                                 advance;

    // A tick moves from the input register into the result register when
    // the result register is empty or is being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata[snjm_pkg::IN_FIELDS_W-1:0];
        end
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    snjm_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    snjm_seq #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .serial_data (in_data_reg[0]),
        .cfg         (cfg),
        .info        (info)
    );

    snjm_matrix u_matrix (
        .info            (info),
        .dpad_select_n   (in_data_reg[1]),
        .action_select_n (in_data_reg[2]),
        .result          (result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(snjm_pkg::OUT_TDATA_W-snjm_pkg::RESULT_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire
